/* src/ffpa_pkg.sv */
// Package with the types, constants and codes of the first-fit partition allocator.
`default_nettype none
package ffpa_pkg;

    localparam int MEM_SIZE  = 128;
    localparam int MAX_PARTS = 16;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        RES_OK      = 3'd0,
        RES_NOSPACE = 3'd1,
        RES_NOPART  = 3'd2,
        RES_FULL    = 3'd3,
        RES_ZERO    = 3'd4
    } res_code_t;

    typedef struct packed {
        cmd_code_t   command;
        logic [7:0]  request_size;
        logic [4:0]  partition_index;
    } req_t;

    typedef struct packed {
        res_code_t   status;
        logic [6:0]  start_address;
        logic [7:0]  part_length;
        logic [4:0]  partition_number;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FSCAN,
        S_FUPD,
        S_USCAN,
        S_UINS,
        S_RREAD,
        S_RSCAN,
        S_RCHK,
        S_RUPD,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic       ready;
        logic       load_in;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       cnt_load_k;
        logic       cap_alloc;
        logic       cap_prev;
        logic       cap_rel;
        logic       cap_next;
        logic       alloc_free_upd;
        logic       alloc_used_ins;
        logic       rel_upd;
        logic       res_load;
        res_code_t  res_code;
    } ctl_cmd_t;

    typedef struct packed {
        logic              cmd_release;
        logic              req_zero;
        logic              used_full;
        logic              idx_bad;
        logic              free_end;
        logic              free_fit;
        logic              free_gt;
        logic              used_end;
        logic              used_gt;
        logic              rel_full;
        logic              out_busy;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  used_count;
    } dp_sts_t;

endpackage
`default_nettype wire

/* src/first_fit_partition_allocator.sv */
// Top level of the first-fit partition allocator with coalescing release.
//
// A request transaction on req carries a command: allocate request_size units,
// or release the partition at 1-based address-order position partition_index.
// Each request gives exactly one response transaction on rsp with a status,
// the start and length of the partition, and its new position after allocate.
// Requests are taken one at a time; req_stall is high while one is in work.
// For an allocate the controller scans the free table, then the allocated
// table, one entry per cycle; for a release it reads the allocated entry and
// scans the free table. Errors found when the request is checked skip the scans.
// The response sits in an output register, so the next request is taken
// while a response still waits; a stalled response holds its value and the
// following result waits until it has been taken.
// After reset the memory is one free region of MEM_SIZE units and no
// partition is allocated.
`default_nettype none
module first_fit_partition_allocator
    import ffpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire req_t  req_data,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    output rsp_t       rsp_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffpa_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .sts       (sts)
    );

    assign req_stall = ~cmd.ready;

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sts.free_count <= CNT_W'(MAX_PARTS) && sts.used_count <= CNT_W'(MAX_PARTS))
        else $error("table count above capacity");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !sts.out_busy)
        else $error("result loaded over a stalled response");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while another is in work");

endmodule
`default_nettype wire

/* src/ffpa_ctrl.sv */
// Controller state machine that sequences the table scans and updates.
`default_nettype none
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    ctl_state_t state_reg, state_next;
    res_code_t  code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.res_code = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.cmd_release)
                begin
                    if (sts.idx_bad)
                    begin
                        code_next  = RES_NOPART;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.cnt_load_k = 1'b1;
                        state_next     = S_RREAD;
                    end
                end
                else if (sts.req_zero)
                begin
                    code_next  = RES_ZERO;
                    state_next = S_DONE;
                end
                else if (sts.used_full)
                begin
                    code_next  = RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                if (sts.free_end)
                begin
                    code_next  = RES_NOSPACE;
                    state_next = S_DONE;
                end
                else if (sts.free_fit)
                begin
                    cmd.cap_alloc = 1'b1;
                    state_next    = S_FUPD;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_FUPD:
            begin
                cmd.alloc_free_upd = 1'b1;
                cmd.cnt_clr        = 1'b1;
                state_next         = S_USCAN;
            end
            S_USCAN:
            begin
                if (sts.used_end || sts.used_gt)
                begin
                    state_next = S_UINS;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_UINS:
            begin
                cmd.alloc_used_ins = 1'b1;
                code_next          = RES_OK;
                state_next         = S_DONE;
            end
            S_RREAD:
            begin
                cmd.cap_rel = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next  = S_RSCAN;
            end
            S_RSCAN:
            begin
                if (sts.free_end || sts.free_gt)
                begin
                    cmd.cap_next = 1'b1;
                    state_next   = S_RCHK;
                end
                else
                begin
                    cmd.cap_prev = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                end
            end
            S_RCHK:
            begin
                if (sts.rel_full)
                begin
                    code_next  = RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RUPD;
                end
            end
            S_RUPD:
            begin
                cmd.rel_upd = 1'b1;
                code_next   = RES_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/ffpa_dpath.sv */
// Datapath with the free and allocated tables, scan counter and result register.
`default_nettype none
module ffpa_dpath
    import ffpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_t      req_data,
    input  wire ctl_cmd_t  cmd,
    input  wire logic      rsp_stall,
    output logic           rsp_valid,
    output rsp_t           rsp_data,
    output dp_sts_t        sts
);

    logic [6:0]       free_start_reg [MAX_PARTS];
    logic [7:0]       free_size_reg  [MAX_PARTS];
    logic [CNT_W-1:0] free_count_reg;
    logic [6:0]       used_start_reg [MAX_PARTS];
    logic [7:0]       used_size_reg  [MAX_PARTS];
    logic [CNT_W-1:0] used_count_reg;

    req_t             in_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] k_reg;
    logic [6:0]       base_reg;
    logic [7:0]       seg_reg;
    logic [7:0]       prev_end_reg;
    logic [7:0]       prev_size_reg;
    logic [7:0]       next_size_reg;
    logic             mnext_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;

    logic [IDX_W-1:0] cidx;
    logic [IDX_W-1:0] pos_m1;
    logic [7:0]       rel_end;
    logic             mprev;
    logic             free_end;
    rsp_t             res_next;

    assign cidx     = cnt_reg[IDX_W-1:0];
    assign pos_m1   = IDX_W'(cnt_reg - 1'b1);
    assign rel_end  = {1'b0, base_reg} + seg_reg;
    assign mprev    = (cnt_reg != '0) && (prev_end_reg == {1'b0, base_reg});
    assign free_end = cnt_reg >= free_count_reg;

    always_comb
    begin
        sts             = '0;
        sts.cmd_release = (in_reg.command == CMD_RELEASE);
        sts.req_zero    = (in_reg.request_size == 8'd0);
        sts.used_full   = used_count_reg >= CNT_W'(MAX_PARTS);
        sts.idx_bad     = (in_reg.partition_index == 5'd0)
                       || (CNT_W'(in_reg.partition_index) > used_count_reg);
        sts.free_end    = free_end;
        sts.free_fit    = free_size_reg[cidx] >= in_reg.request_size;
        sts.free_gt     = free_start_reg[cidx] > base_reg;
        sts.used_end    = cnt_reg >= used_count_reg;
        sts.used_gt     = used_start_reg[cidx] > base_reg;
        sts.rel_full    = !mprev && !mnext_reg
                       && (free_count_reg >= CNT_W'(MAX_PARTS));
        sts.out_busy    = out_valid_reg && rsp_stall;
        sts.free_count  = free_count_reg;
        sts.used_count  = used_count_reg;
    end

    always_comb
    begin
        res_next        = '0;
        res_next.status = cmd.res_code;
        if (cmd.res_code == RES_OK)
        begin
            res_next.start_address = base_reg;
            if (in_reg.command == CMD_ALLOC)
            begin
                res_next.part_length      = in_reg.request_size;
                res_next.partition_number = 5'(cnt_reg + 1'b1);
            end
            else
            begin
                res_next.part_length = seg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= req_data;
        end
        if (cmd.cap_alloc)
        begin
            k_reg    <= cidx;
            base_reg <= free_start_reg[cidx];
            seg_reg  <= free_size_reg[cidx];
        end
        if (cmd.cap_rel)
        begin
            k_reg    <= cidx;
            base_reg <= used_start_reg[cidx];
            seg_reg  <= used_size_reg[cidx];
        end
        if (cmd.cap_prev)
        begin
            prev_end_reg  <= {1'b0, free_start_reg[cidx]} + free_size_reg[cidx];
            prev_size_reg <= free_size_reg[cidx];
        end
        if (cmd.cap_next)
        begin
            mnext_reg     <= !free_end && (rel_end == {1'b0, free_start_reg[cidx]});
            next_size_reg <= free_size_reg[cidx];
        end
        if (cmd.res_load)
        begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_load_k)
            begin
                cnt_reg <= CNT_W'(in_reg.partition_index - 5'd1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PARTS; j++)
            begin
                free_start_reg[j] <= '0;
                free_size_reg[j]  <= (j == 0) ? 8'(MEM_SIZE) : 8'd0;
            end
            free_count_reg <= CNT_W'(1);
        end
        else if (cmd.alloc_free_upd)
        begin
            if (seg_reg == in_reg.request_size)
            begin
                for (int j = 0; j < MAX_PARTS - 1; j++)
                begin
                    if (j >= int'(k_reg))
                    begin
                        free_start_reg[j] <= free_start_reg[j+1];
                        free_size_reg[j]  <= free_size_reg[j+1];
                    end
                end
                free_count_reg <= free_count_reg - 1'b1;
            end
            else
            begin
                free_start_reg[k_reg] <= 7'(base_reg + in_reg.request_size);
                free_size_reg[k_reg]  <= seg_reg - in_reg.request_size;
            end
        end
        else if (cmd.rel_upd)
        begin
            if (mprev && mnext_reg)
            begin
                free_size_reg[pos_m1] <= 8'(prev_size_reg + seg_reg + next_size_reg);
                for (int j = 0; j < MAX_PARTS - 1; j++)
                begin
                    if (j >= int'(cnt_reg))
                    begin
                        free_start_reg[j] <= free_start_reg[j+1];
                        free_size_reg[j]  <= free_size_reg[j+1];
                    end
                end
                free_count_reg <= free_count_reg - 1'b1;
            end
            else if (mprev)
            begin
                free_size_reg[pos_m1] <= 8'(prev_size_reg + seg_reg);
            end
            else if (mnext_reg)
            begin
                free_start_reg[cidx] <= base_reg;
                free_size_reg[cidx]  <= 8'(next_size_reg + seg_reg);
            end
            else
            begin
                for (int j = 1; j < MAX_PARTS; j++)
                begin
                    if (j > int'(cnt_reg))
                    begin
                        free_start_reg[j] <= free_start_reg[j-1];
                        free_size_reg[j]  <= free_size_reg[j-1];
                    end
                end
                free_start_reg[cidx] <= base_reg;
                free_size_reg[cidx]  <= seg_reg;
                free_count_reg       <= free_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_used_ins)
        begin
            for (int j = 1; j < MAX_PARTS; j++)
            begin
                if (j > int'(cnt_reg))
                begin
                    used_start_reg[j] <= used_start_reg[j-1];
                    used_size_reg[j]  <= used_size_reg[j-1];
                end
            end
            used_start_reg[cidx] <= base_reg;
            used_size_reg[cidx]  <= in_reg.request_size;
        end
        else if (cmd.rel_upd)
        begin
            for (int j = 0; j < MAX_PARTS - 1; j++)
            begin
                if (j >= int'(k_reg))
                begin
                    used_start_reg[j] <= used_start_reg[j+1];
                    used_size_reg[j]  <= used_size_reg[j+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (cmd.alloc_used_ins)
        begin
            used_count_reg <= used_count_reg + 1'b1;
        end
        else if (cmd.rel_upd)
        begin
            used_count_reg <= used_count_reg - 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule
`default_nettype wire
